### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted (active low)
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, evaluated in every cycle
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/silal_pkg.sv
// ---------------------------------------------------------------------------
// silal_pkg
// Types, command codes and lane helper function of the packed integer ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package silal_pkg;

    localparam int HALF_W = 64;

    typedef enum logic [3:0] {
        CMD_AND      = 4'd0,
        CMD_OR       = 4'd1,
        CMD_XOR      = 4'd2,
        CMD_NOT      = 4'd3,
        CMD_ADD      = 4'd4,
        CMD_SUB      = 4'd5,
        CMD_MUL      = 4'd6,
        CMD_EQ       = 4'd7,
        CMD_SLT      = 4'd8,
        CMD_SLE      = 4'd9,
        CMD_ULT      = 4'd10,
        CMD_ULE      = 4'd11,
        CMD_SELECT   = 4'd12,
        CMD_SIGNMASK = 4'd13
    } t_cmd;

    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2,
        SIZE_64 = 2'd3
    } t_lane_size;

    typedef struct packed {
        t_cmd       cmd;
        t_lane_size size;
    } t_ctl;

    typedef struct packed {
        logic [HALF_W-1:0] val;
        logic              canon;
        logic [7:0]        signs;
    } t_lane_out;

    typedef struct packed {
        logic [HALF_W-1:0] rl;
        logic [HALF_W-1:0] rh;
        logic              fault;
    } t_result;

    // add, subtract and compares on one lane held zero-extended in 64 bits
    function automatic logic [HALF_W-1:0] silal_alu(
        input t_cmd              cmd,
        input logic [HALF_W-1:0] p,
        input logic [HALF_W-1:0] q,
        input logic [HALF_W-1:0] m,
        input logic [HALF_W-1:0] sb
    );
        logic [HALF_W-1:0] r;
        r = '0;
        unique case (cmd)
            CMD_ADD: r = (p + q) & m;
            CMD_SUB: r = (p - q) & m;
            CMD_EQ:  r = (p == q) ? m : '0;
            CMD_SLT: r = ((p ^ sb) <  (q ^ sb)) ? m : '0;
            CMD_SLE: r = ((p ^ sb) <= (q ^ sb)) ? m : '0;
            CMD_ULT: r = (p <  q) ? m : '0;
            CMD_ULE: r = (p <= q) ? m : '0;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### design/silal_lane.sv
// ---------------------------------------------------------------------------
// silal_lane
// One 64-bit half: lane arithmetic, compares, bitwise ops, select mask check
// and sign bits in the first stage; multiply partials finished in the second.
// ---------------------------------------------------------------------------
`default_nettype none

module silal_lane (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire silal_pkg::t_ctl     i_ctl,
    input  wire silal_pkg::t_ctl     i_ctl_s1,
    input  wire logic [63:0]         i_x,
    input  wire logic [63:0]         i_y,
    input  wire logic [63:0]         i_z,
    output silal_pkg::t_lane_out     o_lane
);
    import silal_pkg::*;

    logic [63:0] a8, a16, a32, a64;
    logic [63:0] t8, t16, t32;
    logic [63:0] n_res;
    logic [63:0] p8, p16;
    logic        c8, c16, c32, c64, n_canon;
    logic [7:0]  n_signs;

    logic [63:0] r_res;
    logic [63:0] r_p8, r_p16;
    logic [63:0] r_ll;
    logic [31:0] r_hh, r_c1, r_c2;
    logic        r_canon;
    logic [7:0]  r_signs;

    logic [63:0] mul_w;

    always_comb begin
        a8 = '0;
        t8 = '0;
        for (int k = 0; k < 8; k++) begin
            t8 = silal_alu(i_ctl.cmd, {56'd0, i_x[8*k +: 8]}, {56'd0, i_y[8*k +: 8]},
                           64'hFF, 64'h80);
            a8[8*k +: 8] = t8[7:0];
        end
    end

    always_comb begin
        a16 = '0;
        t16 = '0;
        for (int k = 0; k < 4; k++) begin
            t16 = silal_alu(i_ctl.cmd, {48'd0, i_x[16*k +: 16]}, {48'd0, i_y[16*k +: 16]},
                            64'hFFFF, 64'h8000);
            a16[16*k +: 16] = t16[15:0];
        end
    end

    always_comb begin
        a32 = '0;
        t32 = '0;
        for (int k = 0; k < 2; k++) begin
            t32 = silal_alu(i_ctl.cmd, {32'd0, i_x[32*k +: 32]}, {32'd0, i_y[32*k +: 32]},
                            64'hFFFF_FFFF, 64'h8000_0000);
            a32[32*k +: 32] = t32[31:0];
        end
    end

    assign a64 = silal_alu(i_ctl.cmd, i_x, i_y, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'h8000_0000_0000_0000);

    always_comb begin
        p8  = '0;
        p16 = '0;
        c8  = 1'b1;
        c16 = 1'b1;
        c32 = 1'b1;
        for (int k = 0; k < 8; k++) begin
            p8[8*k +: 8] = i_x[8*k +: 8] * i_y[8*k +: 8];
            c8 = c8 & ((i_x[8*k +: 8] == 8'h00) | (i_x[8*k +: 8] == 8'hFF));
        end
        for (int k = 0; k < 4; k++) begin
            p16[16*k +: 16] = i_x[16*k +: 16] * i_y[16*k +: 16];
            c16 = c16 & ((i_x[16*k +: 16] == 16'h0000) | (i_x[16*k +: 16] == 16'hFFFF));
        end
        for (int k = 0; k < 2; k++) begin
            c32 = c32 & ((i_x[32*k +: 32] == 32'h0) | (i_x[32*k +: 32] == 32'hFFFF_FFFF));
        end
        c64 = (i_x == 64'h0) | (i_x == 64'hFFFF_FFFF_FFFF_FFFF);
    end

    always_comb begin
        n_signs = '0;
        unique case (i_ctl.size)
            SIZE_8: begin
                for (int k = 0; k < 8; k++) begin
                    n_signs[k] = i_x[8*k + 7];
                end
                n_canon = c8;
            end
            SIZE_16: begin
                n_signs[3:0] = {i_x[63], i_x[47], i_x[31], i_x[15]};
                n_canon = c16;
            end
            SIZE_32: begin
                n_signs[1:0] = {i_x[63], i_x[31]};
                n_canon = c32;
            end
            SIZE_64: begin
                n_signs[0] = i_x[63];
                n_canon = c64;
            end
            default: begin
                n_canon = c64;
            end
        endcase
    end

    always_comb begin
        unique case (i_ctl.cmd)
            CMD_AND:    n_res = i_x & i_y;
            CMD_OR:     n_res = i_x | i_y;
            CMD_XOR:    n_res = i_x ^ i_y;
            CMD_NOT:    n_res = ~i_x;
            CMD_SELECT: n_res = (i_x & i_y) | (~i_x & i_z);
            CMD_ADD, CMD_SUB, CMD_EQ, CMD_SLT, CMD_SLE, CMD_ULT, CMD_ULE: begin
                unique case (i_ctl.size)
                    SIZE_8:  n_res = a8;
                    SIZE_16: n_res = a16;
                    SIZE_32: n_res = a32;
                    SIZE_64: n_res = a64;
                    default: n_res = a64;
                endcase
            end
            default:    n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res   <= n_res;
            r_p8    <= p8;
            r_p16   <= p16;
            r_ll    <= 64'(i_x[31:0]) * 64'(i_y[31:0]);
            r_hh    <= i_x[63:32] * i_y[63:32];
            r_c1    <= i_x[31:0] * i_y[63:32];
            r_c2    <= i_x[63:32] * i_y[31:0];
            r_canon <= n_canon;
            r_signs <= n_signs;
        end
    end

    always_comb begin
        unique case (i_ctl_s1.size)
            SIZE_8:  mul_w = r_p8;
            SIZE_16: mul_w = r_p16;
            SIZE_32: mul_w = {r_hh, r_ll[31:0]};
            SIZE_64: mul_w = r_ll + {r_c1 + r_c2, 32'd0};
            default: mul_w = r_ll;
        endcase
    end

    assign o_lane.val   = (i_ctl_s1.cmd == CMD_MUL) ? mul_w : r_res;
    assign o_lane.canon = r_canon;
    assign o_lane.signs = r_signs;

endmodule

`default_nettype wire

### design/silal_merge.sv
// ---------------------------------------------------------------------------
// silal_merge
// Combine both halves: select mask fault, sign mask assembly, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module silal_merge (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire silal_pkg::t_ctl       i_ctl,
    input  wire silal_pkg::t_lane_out  i_lo,
    input  wire silal_pkg::t_lane_out  i_hi,
    output silal_pkg::t_result         o_result
);
    import silal_pkg::*;

    t_result     n_result;
    t_result     r_result;
    logic [63:0] smask;

    always_comb begin
        unique case (i_ctl.size)
            SIZE_8:  smask = {48'd0, i_hi.signs, i_lo.signs};
            SIZE_16: smask = {56'd0, i_hi.signs[3:0], i_lo.signs[3:0]};
            SIZE_32: smask = {60'd0, i_hi.signs[1:0], i_lo.signs[1:0]};
            SIZE_64: smask = {62'd0, i_hi.signs[0], i_lo.signs[0]};
            default: smask = '0;
        endcase
    end

    always_comb begin
        n_result.rl    = i_lo.val;
        n_result.rh    = i_hi.val;
        n_result.fault = 1'b0;
        unique case (i_ctl.cmd)
            CMD_SELECT: begin
                if (!(i_lo.canon && i_hi.canon)) begin
                    n_result.rl    = '0;
                    n_result.rh    = '0;
                    n_result.fault = 1'b1;
                end
            end
            CMD_SIGNMASK: begin
                n_result.rl = smask;
                n_result.rh = '0;
            end
            default: begin
                n_result.fault = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

### design/simd_integer_lane_alu_core.sv
// ---------------------------------------------------------------------------
// simd_integer_lane_alu_core
// 128-bit packed integer ALU: two 64-bit lane units and a merging stage.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) takes one operation per transaction: command,
//   lane size and three 128-bit operands as 64-bit halves in i_s_tdata.
//   Master channel (o_m_*) returns one result transaction per operation,
//   in order: both result halves and the select mask fault flag.
//   From accept to o_m_tvalid a result passes the lane stage
//   (including the registered 32x32 multiply partials) and the merge
//   stage with its output register.
//   Throughput is one transaction per cycle while i_m_tready is high;
//   both stages advance on their own, so a bubble in either stage is
//   filled while the output waits.
//   When i_m_tready is low the output register holds its result; the
//   lane stage still accepts one more transaction, then o_s_tready
//   drops until the output is taken.
//   Reset empties both stages; data and control registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module simd_integer_lane_alu_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // command[3:0], lane_size[5:4], a_low[69:6], a_high[133:70],
    // b_low[197:134], b_high[261:198], c_low[325:262], c_high[389:326], pad
    input  wire logic [391:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // result_low[63:0], result_high[127:64], mask_fault[128], pad
    output logic [135:0]      o_m_tdata
);
    import silal_pkg::*;

    `include "assert_macros.svh"

    t_ctl      in_ctl;
    t_ctl      r_ctl;
    logic      r_s1_v, n_s1_v;
    logic      r_out_v, n_out_v;
    logic      s1_rdy, out_rdy, accept, out_ld;
    t_lane_out lane_lo, lane_hi;
    t_result   result;

    assign in_ctl.cmd  = t_cmd'(i_s_tdata[3:0]);
    assign in_ctl.size = t_lane_size'(i_s_tdata[5:4]);

    assign out_rdy = !r_out_v || i_m_tready;
    assign s1_rdy  = !r_s1_v || out_rdy;
    assign accept  = i_s_tvalid && s1_rdy;
    assign out_ld  = r_s1_v && out_rdy;

    always_comb begin
        n_s1_v  = s1_rdy ? i_s_tvalid : r_s1_v;
        n_out_v = out_rdy ? r_s1_v : r_out_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl <= in_ctl;
        end
    end

    silal_lane u_lane_lo (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_ctl    (in_ctl),
        .i_ctl_s1 (r_ctl),
        .i_x      (i_s_tdata[69:6]),
        .i_y      (i_s_tdata[197:134]),
        .i_z      (i_s_tdata[325:262]),
        .o_lane   (lane_lo)
    );

    silal_lane u_lane_hi (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_ctl    (in_ctl),
        .i_ctl_s1 (r_ctl),
        .i_x      (i_s_tdata[133:70]),
        .i_y      (i_s_tdata[261:198]),
        .i_z      (i_s_tdata[389:326]),
        .o_lane   (lane_hi)
    );

    silal_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (out_ld),
        .i_ctl    (r_ctl),
        .i_lo     (lane_lo),
        .i_hi     (lane_hi),
        .o_result (result)
    );

    assign o_s_tready = s1_rdy;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {7'd0, result.fault, result.rh, result.rl};

    `ASSERT_CLK(a_fault_zero, i_clk, i_rst_n, (o_m_tvalid && o_m_tdata[128]) |-> (o_m_tdata[127:0] == 128'd0), "fault result not zero")
    `ASSERT_CLK(a_stage_hold, i_clk, i_rst_n, (r_s1_v && r_out_v && !i_m_tready) |=> r_s1_v, "lane stage dropped a transaction")
    `ASSERT_CLK(a_empty_ready, i_clk, i_rst_n, (!r_s1_v && !r_out_v) |-> o_s_tready, "empty pipeline not ready")

endmodule

`default_nettype wire
